FILE: rtl/core/bht_pkg.sv
// Shared types, constants and entry update functions of the branch history table.
package bht_pkg;

	localparam int unsigned ENTRIES = 1024;
	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned ST_W = 2;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned IN_DATA_W = 72;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned PC_W = 64;
	localparam int unsigned IDX_LSB = 2;

	localparam logic [MODE_W-1:0] MODE_NEVER = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALWAYS = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ONEBIT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SAT2 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ALT2 = 3'd4;

	localparam logic [ST_W-1:0] ST_SNT = 2'd0;
	localparam logic [ST_W-1:0] ST_WNT = 2'd1;
	localparam logic [ST_W-1:0] ST_WT = 2'd2;
	localparam logic [ST_W-1:0] ST_ST = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ST_W-1:0] st_t;
	typedef logic [MODE_W-1:0] mode_t;

	typedef struct packed {
		logic busy;
		idx_t addr;
	} clr_t;

	function automatic st_t fill_value(mode_t mode);
		st_t f;
		case (mode)
			MODE_ONEBIT: f = ST_WNT;
			MODE_SAT2: f = ST_WT;
			MODE_ALT2: f = ST_WT;
			default: f = ST_SNT;
		endcase
		return f;
	endfunction

	function automatic logic predict(mode_t mode, st_t s);
		logic p;
		case (mode)
			MODE_ALWAYS: p = 1'b1;
			MODE_ONEBIT: p = s[0];
			MODE_SAT2: p = s[1];
			MODE_ALT2: p = s[1];
			default: p = 1'b0;
		endcase
		return p;
	endfunction

	function automatic st_t next_state(mode_t mode, st_t s, logic t);
		st_t n;
		n = s;
		case (mode)
			MODE_ONEBIT: n = {1'b0, t};
			MODE_SAT2: begin
				if (t) begin
					if (s != ST_ST) n = s + 2'd1;
				end else begin
					if (s != ST_SNT) n = s - 2'd1;
				end
			end
			MODE_ALT2: begin
				case (s)
					ST_SNT: n = t ? ST_WNT : ST_SNT;
					ST_WNT: n = t ? ST_ST : ST_SNT;
					ST_WT: n = t ? ST_ST : ST_SNT;
					default: n = t ? ST_ST : ST_WT;
				endcase
			end
			default: n = s;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/core/bht_ram.sv
// Simple dual-port table memory with one write port and a registered read port.
module bht_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 2,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/bht_clear.sv
// Table reload sequencer that sweeps every entry after reset and after a mode write.
module bht_clear (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	output bht_pkg::clr_t clr
);

	logic          busy_q;
	bht_pkg::idx_t cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (restart) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == bht_pkg::IDX_W'(bht_pkg::ENTRIES - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + bht_pkg::idx_t'(1);
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = cnt_q;

endmodule

FILE: rtl/core/branch_history_table_predictor.sv
// Top level of the bimodal branch history table predictor.
// Each accepted word (predict or update) returns one prediction word taken from
// the entry's state before any change. The table sits in one synchronous memory:
// the entry is read when the word is accepted, and modified and written back as
// it leaves stage s1, with a bypass when the next word hits the same entry, so a
// new word is taken every cycle unless the output stalls, and its prediction is
// presented through stage s1 and then an output register. After reset and after
// every write of the mode register the table is reloaded by a sweep over all
// 1024 entries, one entry per cycle, during which no input word is accepted.
module branch_history_table_predictor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bht_pkg::MODE_W-1:0]      cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Bits from the lowest up: branch_pc[63:0], taken, zero padding.
	input  logic [bht_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// Bits from the lowest up: cmd.
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Bits from the lowest up: predict_taken, zero padding.
	output logic [bht_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	bht_pkg::mode_t mode_q;
	bht_pkg::clr_t  clr;

	logic          valid_s1;
	logic          cmd_s1;
	logic          taken_s1;
	bht_pkg::idx_t idx_s1;
	logic          fwd_s1;
	bht_pkg::st_t  fwd_data_s1;

	logic          out_valid_q;
	logic          out_pred_q;

	logic          advance;
	logic          accept;
	bht_pkg::idx_t idx_in;
	bht_pkg::st_t  rdata;
	bht_pkg::st_t  cur_s1;
	bht_pkg::st_t  nxt_s1;
	logic          wr_en;
	bht_pkg::idx_t wr_addr;
	bht_pkg::st_t  wr_data;

	assign idx_in = s_axis_tdata[bht_pkg::IDX_LSB +: bht_pkg::IDX_W];
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr.busy && (!valid_s1 || advance);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign cur_s1 = fwd_s1 ? fwd_data_s1 : rdata;
	assign nxt_s1 = bht_pkg::next_state(mode_q, cur_s1, taken_s1);

	always_comb begin
		if (clr.busy) begin
			wr_en = 1'b1;
			wr_addr = clr.addr;
			wr_data = bht_pkg::fill_value(mode_q);
		end else begin
			wr_en = advance && cmd_s1;
			wr_addr = idx_s1;
			wr_data = nxt_s1;
		end
	end

	bht_clear u_clear (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.clr     (clr)
	);

	bht_ram #(
		.DEPTH (bht_pkg::ENTRIES),
		.WIDTH (bht_pkg::ST_W),
		.AW    (bht_pkg::IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (idx_in),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bht_pkg::MODE_SAT2;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1 <= advance && cmd_s1 && (idx_s1 == idx_in);
		end else if (advance) begin
			valid_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= s_axis_tuser;
			taken_s1 <= s_axis_tdata[bht_pkg::PC_W];
			idx_s1 <= idx_in;
			fwd_data_s1 <= nxt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pred_q <= bht_pkg::predict(mode_q, cur_s1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(bht_pkg::OUT_DATA_W - 1){1'b0}}, out_pred_q};

endmodule
